// ----- rtl/core/fmbl_pkg.sv -----
package fmbl_pkg;

  // Default table geometry
  localparam int unsigned DEF_ROWS = 16;
  localparam int unsigned DEF_COLS = 16;

  // Depth of the queue between the front and the back
  localparam int unsigned FIFO_DEPTH = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FUEL_GAIN = 3'd5;

  // Item function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Coordinate division: dividend covers a 16 bit span times 63 times 256,
  // quotient covers the last index of a 64 entry axis with 8 fraction bits.
  localparam int unsigned NUM_W   = 30;
  localparam int unsigned CQ_W    = 14;
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned PULSE_W = 24;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    AX_ZERO,
    AX_TOP,
    AX_DIV
  } axis_e;

  typedef struct packed {
    logic        func;
    logic [15:0] map_reading;
    logic [13:0] rpm_reading;
    logic [9:0]  intake_temp;
    logic        in_starting;
    logic [15:0] startup_gain;
    logic [3:0]  table_row;
    logic [3:0]  table_col;
    logic [31:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [23:0] pulse_time;
    logic        saturated;
    logic        temp_error;
  } out_t;

  typedef struct packed {
    logic [15:0] map_min;
    logic [15:0] map_max;
    logic [13:0] rpm_min;
    logic [13:0] rpm_max;
    logic [15:0] open_time;
    logic [15:0] fuel_gain;
  } cfg_t;

  typedef struct packed {
    in_t              item;
    axis_e            rcode;
    axis_e            ccode;
    logic [NUM_W-1:0] rnum;
    logic [NUM_W-1:0] cnum;
    logic [15:0]      rden;
    logic [15:0]      cden;
  } qitem_t;

  typedef struct packed {
    in_t   item;
    axis_e rcode;
  } rside_t;

  typedef struct packed {
    logic        func;
    logic        tzero;
    logic        starting;
    logic [15:0] sgain;
  } tside_t;

endpackage

// ----- rtl/core/fmbl_ram.sv -----
module fmbl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/fmbl_fifo.sv -----
module fmbl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fmbl_pkg::qitem_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output fmbl_pkg::qitem_t data_o
);

  localparam int unsigned AW = $clog2(fmbl_pkg::FIFO_DEPTH);

  fmbl_pkg::qitem_t mem_q [fmbl_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(fmbl_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/fmbl_div.sv -----
module fmbl_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 10,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          ovf_q  [QW];
  logic          vld_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int unsigned B = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          ovf_in, vld_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
      // Quotient does not fit in QW bits
      assign ovf_in  = (num_i >> QW) >= NW'(den_i);
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign ovf_in  = ovf_q[k-1];
    end

    assign ge = (rem_in >> B) >= NW'(den_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_in - (NW'(den_in) << B)) : rem_in;
        quo_q[k]  <= quo_in | (ge ? (QW'(1) << B) : '0);
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        ovf_q[k]  <= ovf_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = quo_q[QW-1];
  assign ovf_o  = ovf_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

// ----- rtl/core/fmbl_front.sv -----
module fmbl_front #(
  parameter int unsigned TABLE_ROWS = fmbl_pkg::DEF_ROWS,
  parameter int unsigned TABLE_COLS = fmbl_pkg::DEF_COLS
) (
  input  fmbl_pkg::in_t    item_i,
  input  fmbl_pkg::cfg_t   cfg_i,
  output fmbl_pkg::qitem_t qitem_o
);

  function automatic fmbl_pkg::axis_e axis_code(logic [15:0] rd, logic [15:0] lo,
                                                logic [15:0] hi);
    fmbl_pkg::axis_e c;
    if (hi == lo) begin
      c = (rd < lo) ? fmbl_pkg::AX_ZERO : fmbl_pkg::AX_TOP;
    end else if ((rd == lo) || ((rd < lo) != (hi < lo))) begin
      c = fmbl_pkg::AX_ZERO;
    end else begin
      c = fmbl_pkg::AX_DIV;
    end
    return c;
  endfunction

  function automatic logic [15:0] abs_diff(logic [15:0] a, logic [15:0] b);
    return (a < b) ? (b - a) : (a - b);
  endfunction

  logic [15:0] rpm_rd, rpm_lo, rpm_hi;
  logic [15:0] rabs, cabs;

  assign rpm_rd = {2'b00, item_i.rpm_reading};
  assign rpm_lo = {2'b00, cfg_i.rpm_min};
  assign rpm_hi = {2'b00, cfg_i.rpm_max};
  assign rabs   = abs_diff(item_i.map_reading, cfg_i.map_min);
  assign cabs   = abs_diff(rpm_rd, rpm_lo);

  always_comb begin
    qitem_o.item  = item_i;
    qitem_o.rcode = axis_code(item_i.map_reading, cfg_i.map_min, cfg_i.map_max);
    qitem_o.ccode = axis_code(rpm_rd, rpm_lo, rpm_hi);
    // Scale the span onto the axis with 8 fraction bits
    qitem_o.rnum  = (fmbl_pkg::NUM_W'(rabs) * fmbl_pkg::NUM_W'(TABLE_ROWS - 1)) << 8;
    qitem_o.cnum  = (fmbl_pkg::NUM_W'(cabs) * fmbl_pkg::NUM_W'(TABLE_COLS - 1)) << 8;
    qitem_o.rden  = abs_diff(cfg_i.map_max, cfg_i.map_min);
    qitem_o.cden  = abs_diff(rpm_hi, rpm_lo);
  end

endmodule

// ----- rtl/core/fmbl_back.sv -----
module fmbl_back #(
  parameter int unsigned TABLE_ROWS = fmbl_pkg::DEF_ROWS,
  parameter int unsigned TABLE_COLS = fmbl_pkg::DEF_COLS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fmbl_pkg::cfg_t   cfg_i,
  input  fmbl_pkg::qitem_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output fmbl_pkg::out_t   out_data_o
);

  localparam int unsigned RIW  = $clog2(TABLE_ROWS);
  localparam int unsigned CIW  = $clog2(TABLE_COLS);
  localparam int unsigned HR   = (TABLE_ROWS + 1) / 2;
  localparam int unsigned HC   = (TABLE_COLS + 1) / 2;
  localparam int unsigned BDEP = HR * HC;
  localparam int unsigned BAW  = (BDEP > 1) ? $clog2(BDEP) : 1;
  localparam int unsigned RSW  = $bits(fmbl_pkg::rside_t);
  localparam int unsigned TSW  = $bits(fmbl_pkg::tside_t);
  localparam logic [fmbl_pkg::CQ_W-1:0] RTOP = fmbl_pkg::CQ_W'((TABLE_ROWS - 1) * 256);
  localparam logic [fmbl_pkg::CQ_W-1:0] CTOP = fmbl_pkg::CQ_W'((TABLE_COLS - 1) * 256);

  function automatic logic [fmbl_pkg::CQ_W-1:0] coord(fmbl_pkg::axis_e code,
                                                      logic [fmbl_pkg::CQ_W-1:0] q,
                                                      logic ovf,
                                                      logic [fmbl_pkg::CQ_W-1:0] top);
    logic [fmbl_pkg::CQ_W-1:0] c;
    unique case (code)
      fmbl_pkg::AX_ZERO: c = '0;
      fmbl_pkg::AX_TOP:  c = top;
      default:           c = (ovf || (q > top)) ? top : q;
    endcase
    return c;
  endfunction

  logic en;

  // Coordinate dividers
  logic                      rd_vld, cd_vld, rd_ovf, cd_ovf;
  logic [fmbl_pkg::CQ_W-1:0] rd_q, cd_q;
  logic [RSW-1:0]            rd_side;
  logic [1:0]                cd_side;
  fmbl_pkg::rside_t          rs;
  fmbl_pkg::axis_e           ccode;

  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && !empty_i;

  fmbl_div #(
    .NW(fmbl_pkg::NUM_W), .DW(16), .QW(fmbl_pkg::CQ_W), .SW(RSW)
  ) u_row_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(!empty_i),
    .num_i(head_i.rnum), .den_i(head_i.rden),
    .side_i(fmbl_pkg::rside_t'{item: head_i.item, rcode: head_i.rcode}),
    .vld_o(rd_vld), .quo_o(rd_q), .ovf_o(rd_ovf), .side_o(rd_side)
  );

  fmbl_div #(
    .NW(fmbl_pkg::NUM_W), .DW(16), .QW(fmbl_pkg::CQ_W), .SW(2)
  ) u_col_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(!empty_i),
    .num_i(head_i.cnum), .den_i(head_i.cden), .side_i(head_i.ccode),
    .vld_o(cd_vld), .quo_o(cd_q), .ovf_o(cd_ovf), .side_o(cd_side)
  );

  assign rs    = fmbl_pkg::rside_t'(rd_side);
  assign ccode = fmbl_pkg::axis_e'(cd_side);

  // Cell selection and table access
  logic [fmbl_pkg::CQ_W-1:0] rc, cc;
  logic [RIW-1:0]            ri, r1;
  logic [CIW-1:0]            ci, c1;
  logic                      interior, c_vld;
  logic [8:0]                wr0, wr1, wc0, wc1;
  logic [RIW-1:0]            rsel [4];
  logic [CIW-1:0]            csel [4];
  logic [BAW-1:0]            raddr [4];
  logic [BAW-1:0]            waddr;
  logic                      wok;
  logic [1:0]                wbank;
  logic [fmbl_pkg::ENTRY_W-1:0] rdata [4];

  assign c_vld    = rd_vld && cd_vld;
  assign rc       = coord(rs.rcode, rd_q, rd_ovf, RTOP);
  assign cc       = coord(ccode, cd_q, cd_ovf, CTOP);
  assign ri       = rc[8 +: RIW];
  assign ci       = cc[8 +: CIW];
  assign interior = (ri < RIW'(TABLE_ROWS - 1)) && (ci < CIW'(TABLE_COLS - 1));
  assign r1       = interior ? ri + RIW'(1) : ri;
  assign c1       = interior ? ci + CIW'(1) : ci;
  assign wr1      = {1'b0, rc[7:0]};
  assign wr0      = 9'd256 - wr1;
  assign wc1      = {1'b0, cc[7:0]};
  assign wc0      = 9'd256 - wc1;

  // Row parity picks the bank row, column parity the bank column
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rsel[b]  = (b[1] == ri[0]) ? ri : r1;
      csel[b]  = (b[0] == ci[0]) ? ci : c1;
      raddr[b] = BAW'(int'(rsel[b] >> 1) * HC + int'(csel[b] >> 1));
    end
  end

  assign wok   = c_vld && (rs.item.func == fmbl_pkg::FUNC_WRITE) &&
                 (int'(rs.item.table_row) < TABLE_ROWS) &&
                 (int'(rs.item.table_col) < TABLE_COLS);
  assign wbank = {rs.item.table_row[0], rs.item.table_col[0]};
  assign waddr = BAW'(int'(rs.item.table_row >> 1) * HC + int'(rs.item.table_col >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    fmbl_ram #(
      .WIDTH(fmbl_pkg::ENTRY_W), .DEPTH(BDEP), .AW(BAW)
    ) u_ram (
      .clk_i,
      .we_i   (en && wok && (wbank == 2'(b))),
      .waddr_i(waddr),
      .wdata_i(rs.item.entry_value),
      .re_i   (en),
      .raddr_i(raddr[b]),
      .rdata_o(rdata[b])
    );
  end

  // Stage M: weights, waiting for the table read
  logic          m_vld_q, m_int_q, m_pr_q, m_pc_q;
  logic [16:0]   m_w_q [4];
  fmbl_pkg::in_t m_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_item_q <= rs.item;
      m_int_q  <= interior;
      m_pr_q   <= ri[0];
      m_pc_q   <= ci[0];
      m_w_q[0] <= 17'(wr0) * 17'(wc0);
      m_w_q[1] <= 17'(wr1) * 17'(wc0);
      m_w_q[2] <= 17'(wr0) * 17'(wc1);
      m_w_q[3] <= 17'(wr1) * 17'(wc1);
    end
  end

  // Stage P: weighted corners
  logic [fmbl_pkg::ENTRY_W-1:0] e [4];
  logic [48:0]   prod [4];
  logic          p_vld_q, p_int_q;
  logic [47:0]   p_prod_q [4];
  logic [fmbl_pkg::ENTRY_W-1:0] p_e00_q;
  fmbl_pkg::in_t p_item_q;

  always_comb begin
    e[0] = rdata[{m_pr_q, m_pc_q}];
    e[1] = rdata[{!m_pr_q, m_pc_q}];
    e[2] = rdata[{m_pr_q, !m_pc_q}];
    e[3] = rdata[{!m_pr_q, !m_pc_q}];
    for (int i = 0; i < 4; i++) begin
      prod[i] = {17'b0, e[i]} * {32'b0, m_w_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p_prod_q[i] <= prod[i][47:0];
      end
      p_e00_q  <= e[0];
      p_int_q  <= m_int_q;
      p_item_q <= m_item_q;
    end
  end

  // Stage S: partial sums
  logic          s_vld_q, s_int_q;
  logic [47:0]   s_a_q, s_b_q;
  logic [fmbl_pkg::ENTRY_W-1:0] s_e00_q;
  fmbl_pkg::in_t s_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (en) begin
      s_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_a_q    <= p_prod_q[0] + p_prod_q[1];
      s_b_q    <= p_prod_q[2] + p_prod_q[3];
      s_e00_q  <= p_e00_q;
      s_int_q  <= p_int_q;
      s_item_q <= p_item_q;
    end
  end

  // Stage V: interpolated value, corner entry on the last row or column
  logic [47:0]   vsum;
  logic          v_vld_q;
  logic [fmbl_pkg::ENTRY_W-1:0] v_q;
  fmbl_pkg::in_t v_item_q;
  fmbl_pkg::tside_t v_side;

  assign vsum = s_a_q + s_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= 1'b0;
    end else if (en) begin
      v_vld_q <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q      <= s_int_q ? vsum[47:16] : s_e00_q;
      v_item_q <= s_item_q;
    end
  end

  assign v_side = '{func:     v_item_q.func,
                    tzero:    (v_item_q.intake_temp == '0),
                    starting: v_item_q.in_starting,
                    sgain:    v_item_q.startup_gain};

  // Temperature divider
  logic                         td_vld;
  logic [fmbl_pkg::ENTRY_W-1:0] td_q;
  logic [TSW-1:0]               td_side;
  fmbl_pkg::tside_t             ts;

  fmbl_div #(
    .NW(fmbl_pkg::ENTRY_W), .DW(10), .QW(fmbl_pkg::ENTRY_W), .SW(TSW)
  ) u_temp_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_vld_q),
    .num_i(v_q), .den_i(v_item_q.intake_temp), .side_i(v_side),
    .vld_o(td_vld), .quo_o(td_q), .ovf_o(), .side_o(td_side)
  );

  assign ts = fmbl_pkg::tside_t'(td_side);

  // Stage G: startup gain
  logic [47:0]      sprod;
  logic             g_vld_q;
  logic [35:0]      g_q;
  fmbl_pkg::tside_t g_side_q;

  assign sprod = {16'b0, td_q} * {32'b0, ts.sgain};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= td_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q      <= ts.starting ? sprod[47:12] : {4'b0, td_q};
      g_side_q <= ts;
    end
  end

  // Stage F: fuel gain
  logic [51:0]      fprod;
  logic             f_vld_q;
  logic [43:0]      f_q;
  fmbl_pkg::tside_t f_side_q;

  assign fprod = {16'b0, g_q} * {36'b0, cfg_i.fuel_gain};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q      <= fprod[51:8];
      f_side_q <= g_side_q;
    end
  end

  // Output register: dead time, saturation, special results
  logic [44:0]    psum;
  logic           sat;
  fmbl_pkg::out_t res;
  logic           out_vld_q;
  fmbl_pkg::out_t out_q;

  assign psum = {1'b0, f_q} + 45'(cfg_i.open_time);
  assign sat  = psum > 45'(fmbl_pkg::PULSE_MAX);

  always_comb begin
    res = '0;
    if (f_side_q.func == fmbl_pkg::FUNC_WRITE) begin
      res = '0;
    end else if (f_side_q.tzero) begin
      res.temp_error = 1'b1;
    end else begin
      res.pulse_time = sat ? fmbl_pkg::PULSE_MAX : psum[23:0];
      res.saturated  = sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/fuel_map_bilinear_pulse_lookup.sv -----
// Fuel map lookup: stores a table of base injector pulse times and turns
// pressure, speed and intake temperature into an injector pulse length.
// Input channel (in_valid_i / in_stall_o / in_data_i): a write item stores
// one table entry, a lookup item asks for one pulse. Every item, write or
// lookup, gives exactly one result on the output channel
// (out_valid_o / out_stall_i / out_data_o), in order.
// From transfer to result an item passes the bit-per-cycle coordinate
// division, the table read and interpolation, the bit-per-cycle
// temperature division, two gain multiplies and the output register.
// Throughput is one item per cycle while the output is not stalled; the
// table sits in four banks split by row and column parity so the four
// corners of a cell are read in the same cycle.
// A stalled result holds in the output register and freezes the back
// pipeline; the front keeps taking items into a 4 entry queue and raises
// in_stall_o only when that queue is full.
// Reset empties the queue and pipeline and restores register defaults.
// Table entries are undefined until written; write every entry a lookup
// can reach before using it. Configuration (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) takes effect at the write edge; write only while idle.
module fuel_map_bilinear_pulse_lookup #(
  parameter int unsigned TABLE_ROWS = fmbl_pkg::DEF_ROWS,
  parameter int unsigned TABLE_COLS = fmbl_pkg::DEF_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fmbl_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fmbl_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [fmbl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fmbl_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  fmbl_pkg::cfg_t   cfg_q;
  fmbl_pkg::qitem_t front_item, head;
  logic             fifo_full, fifo_empty, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_min   <= 16'd0;
      cfg_q.map_max   <= 16'hFFFF;
      cfg_q.rpm_min   <= 14'd0;
      cfg_q.rpm_max   <= 14'h3FFF;
      cfg_q.open_time <= 16'd0;
      cfg_q.fuel_gain <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fmbl_pkg::CFG_MAP_MIN:   cfg_q.map_min   <= cfg_wdata_i;
        fmbl_pkg::CFG_MAP_MAX:   cfg_q.map_max   <= cfg_wdata_i;
        fmbl_pkg::CFG_RPM_MIN:   cfg_q.rpm_min   <= cfg_wdata_i[13:0];
        fmbl_pkg::CFG_RPM_MAX:   cfg_q.rpm_max   <= cfg_wdata_i[13:0];
        fmbl_pkg::CFG_OPEN_TIME: cfg_q.open_time <= cfg_wdata_i;
        fmbl_pkg::CFG_FUEL_GAIN: cfg_q.fuel_gain <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: classify each axis and scale its span for division
  fmbl_front #(
    .TABLE_ROWS(TABLE_ROWS), .TABLE_COLS(TABLE_COLS)
  ) u_front (
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .qitem_o(front_item)
  );

  // Hold the input side only when the queue is full
  assign in_stall_o = fifo_full;

  fmbl_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (in_valid_i),
    .data_i (front_item),
    .full_o (fifo_full),
    .pop_i  (pop),
    .empty_o(fifo_empty),
    .data_o (head)
  );

  // Back: divide, interpolate, scale, saturate
  fmbl_back #(
    .TABLE_ROWS(TABLE_ROWS), .TABLE_COLS(TABLE_COLS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .head_i     (head),
    .empty_i    (fifo_empty),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.pulse_time == fmbl_pkg::PULSE_MAX)
    else $error("saturated result below pulse maximum");

  a_temp_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.temp_error |->
      (out_data_o.pulse_time == '0) && !out_data_o.saturated)
    else $error("temperature error result carries a pulse");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned ROWS = 16;
  localparam int unsigned COLS = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 80;

  // Pulse predictor and in-order store of expected pulses.
  class pulse_scoreboard;
    logic [31:0] base_tbl [ROWS*COLS];
    logic [15:0] map_lo, map_hi, open_us, fuel_q8;
    logic [13:0] rpm_lo, rpm_hi;
    fmbl_pkg::out_t pending_pulses[$];
    int unsigned mismatches;

    function new();
      foreach (base_tbl[i]) base_tbl[i] = '0;
      map_lo = 16'd0;
      map_hi = 16'hFFFF;
      rpm_lo = 14'd0;
      rpm_hi = 14'h3FFF;
      open_us = 16'd0;
      fuel_q8 = 16'd256;
      mismatches = 0;
    endfunction

    function void set_reg(logic [fmbl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        fmbl_pkg::CFG_MAP_MIN:   map_lo = val;
        fmbl_pkg::CFG_MAP_MAX:   map_hi = val;
        fmbl_pkg::CFG_RPM_MIN:   rpm_lo = val[13:0];
        fmbl_pkg::CFG_RPM_MAX:   rpm_hi = val[13:0];
        fmbl_pkg::CFG_OPEN_TIME: open_us = val;
        fmbl_pkg::CFG_FUEL_GAIN: fuel_q8 = val;
        default: ;
      endcase
    endfunction

    // Map a reading onto an 8-bit-fraction coordinate, clamped to the axis.
    function longint unsigned axis_coord(longint unsigned rd, longint unsigned lo,
                                         longint unsigned hi, longint unsigned n);
      longint unsigned top, num, den, q;
      bit num_neg, den_neg;
      top = (n - 1) << 8;
      if (hi == lo) return (rd < lo) ? 0 : top;
      num_neg = rd < lo;
      num = num_neg ? lo - rd : rd - lo;
      den_neg = hi < lo;
      den = den_neg ? lo - hi : hi - lo;
      if (num == 0 || num_neg != den_neg) return 0;
      q = (num * (n - 1) * 256) / den;
      return (q > top) ? top : q;
    endfunction

    function longint unsigned entry(longint unsigned r, longint unsigned c);
      return base_tbl[r*COLS + c];
    endfunction

    function fmbl_pkg::out_t lookup_pulse(fmbl_pkg::in_t it);
      fmbl_pkg::out_t res;
      longint unsigned rc, cc, ri, ci, fr, fc, v, t, p;
      res = '0;
      if (it.func == fmbl_pkg::FUNC_WRITE) begin
        base_tbl[it.table_row*COLS + it.table_col] = it.entry_value;
        return res;
      end
      if (it.intake_temp == 0) begin
        res.temp_error = 1'b1;
        return res;
      end
      rc = axis_coord(it.map_reading, map_lo, map_hi, ROWS);
      cc = axis_coord(it.rpm_reading, rpm_lo, rpm_hi, COLS);
      ri = rc >> 8;
      ci = cc >> 8;
      fr = rc & 255;
      fc = cc & 255;
      if (ri < ROWS - 1 && ci < COLS - 1) begin
        v = entry(ri, ci) * (256 - fr) * (256 - fc)
          + entry(ri + 1, ci) * fr * (256 - fc)
          + entry(ri, ci + 1) * (256 - fr) * fc
          + entry(ri + 1, ci + 1) * fr * fc;
        v = v >> 16;
      end else begin
        v = entry(ri, ci);
      end
      t = v / it.intake_temp;
      if (it.in_starting) t = (t * it.startup_gain) >> 12;
      p = open_us + ((t * fuel_q8) >> 8);
      if (p > 64'hFFFFFF) begin
        p = 64'hFFFFFF;
        res.saturated = 1'b1;
      end
      res.pulse_time = p[23:0];
      return res;
    endfunction

    function void note_item(fmbl_pkg::in_t it);
      pending_pulses.push_back(lookup_pulse(it));
    endfunction

    function void check_result(fmbl_pkg::out_t got);
      fmbl_pkg::out_t want;
      if (pending_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_pulses.pop_front();
      if (got.pulse_time !== want.pulse_time || got.saturated !== want.saturated ||
          got.temp_error !== want.temp_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pulse %0d/%0d sat %b/%b terr %b/%b (expected/actual)",
                   want.pulse_time, got.pulse_time, want.saturated, got.saturated,
                   want.temp_error, got.temp_error);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  fmbl_pkg::in_t  in_data_i;
  fmbl_pkg::out_t out_data_o;
  logic cfg_we_i;
  logic [fmbl_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [fmbl_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  pulse_scoreboard sb;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned cycles;

  fuel_map_bilinear_pulse_lookup u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Check each result transfer, then pick the next stall state.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold valid and payload until the transfer; idle first at random.
  task automatic send_item(fmbl_pkg::in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  task automatic write_entry(int unsigned r, int unsigned c, logic [31:0] val);
    fmbl_pkg::in_t it;
    it = fmbl_pkg::in_t'({2'b00, $urandom, $urandom, $urandom});
    it.func = fmbl_pkg::FUNC_WRITE;
    it.table_row = r[3:0];
    it.table_col = c[3:0];
    it.entry_value = val;
    send_item(it);
  endtask

  task automatic lookup(logic [15:0] mapr, logic [13:0] rpmr, logic [9:0] temp,
                        logic start, logic [15:0] sgain);
    fmbl_pkg::in_t it;
    it = fmbl_pkg::in_t'({2'b00, $urandom, $urandom, $urandom});
    it.func = fmbl_pkg::FUNC_LOOKUP;
    it.map_reading = mapr;
    it.rpm_reading = rpmr;
    it.intake_temp = temp;
    it.in_starting = start;
    it.startup_gain = sgain;
    send_item(it);
  endtask

  // Drop valid and hold off until every expected pulse has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_pulses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all six registers back to back; only legal while idle.
  task automatic load_regs(logic [15:0] mlo, logic [15:0] mhi, logic [13:0] rlo,
                           logic [13:0] rhi, logic [15:0] ot, logic [15:0] fg);
    logic [15:0] vals [6];
    logic [fmbl_pkg::CFG_IDX_W-1:0] idx [6];
    vals = '{mlo, mhi, {2'b0, rlo}, {2'b0, rhi}, ot, fg};
    idx = '{fmbl_pkg::CFG_MAP_MIN, fmbl_pkg::CFG_MAP_MAX, fmbl_pkg::CFG_RPM_MIN,
            fmbl_pkg::CFG_RPM_MAX, fmbl_pkg::CFG_OPEN_TIME, fmbl_pkg::CFG_FUEL_GAIN};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random item: mostly lookups, some readings pinned to the range edges.
  task automatic random_item();
    logic [15:0] mapr;
    logic [13:0] rpmr;
    logic [9:0]  temp;
    if ($urandom_range(99) < 12) begin
      write_entry($urandom_range(15), $urandom_range(15),
                  ($urandom_range(9) == 0) ? 32'hFFFFFFFF : $urandom);
    end else begin
      case ($urandom_range(5))
        0: mapr = sb.map_lo;
        1: mapr = sb.map_hi;
        default: mapr = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0: rpmr = sb.rpm_lo;
        1: rpmr = sb.rpm_hi;
        default: rpmr = 14'($urandom);
      endcase
      case ($urandom_range(9))
        0: temp = 10'd0;
        1: temp = 10'($urandom_range(1, 4));
        default: temp = 10'($urandom);
      endcase
      lookup(mapr, rpmr, temp, 1'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = fmbl_pkg::CFG_MAP_MIN;
    cfg_wdata_i = '0;
    send_idle_pct = 11;
    recv_idle_pct = 46;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole table first so no lookup reads an unwritten entry.
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        write_entry(r, c, (r == 0 && c == 0) ? 32'h0 :
                          (r == ROWS-1 && c == COLS-1) ? 32'hFFFFFFFF : $urandom);

    // Directed: axis edges, temperature extremes, startup gain extremes.
    lookup(16'h0000, 14'h0000, 10'd1, 1'b0, 16'h0000);
    lookup(16'hFFFF, 14'h3FFF, 10'd1, 1'b0, 16'h0000);
    lookup(16'hFFFF, 14'h0000, 10'd1023, 1'b0, 16'h0000);
    lookup(16'h0000, 14'h3FFF, 10'd1023, 1'b1, 16'hFFFF);
    lookup(16'h8000, 14'h2000, 10'd0, 1'b1, 16'hFFFF);
    lookup(16'h7FFF, 14'h1FFF, 10'd300, 1'b1, 16'h1000);
    lookup(16'hF000, 14'h3C00, 10'd1, 1'b1, 16'hFFFF);
    lookup(16'h1234, 14'h1555, 10'd512, 1'b1, 16'h0000);
    write_entry(ROWS-1, 0, 32'hFFFFFFFF);
    write_entry(0, COLS-1, 32'h0);
    lookup(16'hFFFF, 14'h0000, 10'd1, 1'b0, 16'h0000);
    lookup(16'h0000, 14'h3FFF, 10'd1, 1'b0, 16'h0000);
    drain();

    // Equal min and max, below, at and above the point.
    load_regs(16'h8000, 16'h8000, 14'h1000, 14'h1000, 16'hFFFF, 16'hFFFF);
    lookup(16'h7FFF, 14'h0FFF, 10'd1, 1'b0, 16'h0);
    lookup(16'h8000, 14'h1000, 10'd1, 1'b0, 16'h0);
    lookup(16'hFFFF, 14'h0000, 10'd2, 1'b1, 16'hFFFF);
    drain();

    // Reversed ranges.
    load_regs(16'hF000, 16'h1000, 14'h3000, 14'h0100, 16'd0, 16'd0);
    lookup(16'h8000, 14'h1000, 10'd7, 1'b0, 16'h0);
    lookup(16'h0000, 14'h3FFF, 10'd7, 1'b0, 16'h0);
    drain();

    // Random phases: each with its own register setting; pairs of phases share an idling mode.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_regs(16'd0, 16'hFFFF, 14'd0, 14'h3FFF, 16'd0, 16'd256);
        1: load_regs(16'($urandom), 16'($urandom), 14'($urandom), 14'($urandom),
                     16'($urandom), 16'($urandom));
        2: load_regs(16'h0100, 16'h0200, 14'h0040, 14'h0080, 16'd50, 16'd384);
        3: load_regs(16'hFFFF, 16'd0, 14'h3FFF, 14'd0, 16'hFFFF, 16'hFFFF);
        4: load_regs(16'h2000, 16'hE000, 14'h0400, 14'h3800, 16'd0, 16'd0);
        default: load_regs(16'($urandom), 16'($urandom), 14'($urandom), 14'($urandom),
                           16'($urandom), 16'($urandom_range(1, 1024)));
      endcase
      if (ph < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 46;
      end else if (ph < 4) begin
        send_idle_pct = 46;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 150; n++) random_item();
      // Advance the same setting after a full pause once.
      if (ph == 1) begin
        drain();
        for (int n = 0; n < 20; n++) random_item();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_pulses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fmbl_pkg.sv
rtl/core/fmbl_ram.sv
rtl/core/fmbl_fifo.sv
rtl/core/fmbl_div.sv
rtl/core/fmbl_front.sv
rtl/core/fmbl_back.sv
rtl/core/fuel_map_bilinear_pulse_lookup.sv
verif/tb_top.sv
